// ===== hdl/scp_pkg.sv =====
// Shared constants and types for the sine commutation PWM block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package scp_pkg;

    // Quarter-wave length; must be a power of two so that the turn is a bit field
    localparam int QUARTER_SAMPLES = 1024;
    localparam int QTR_BITS        = $clog2(QUARTER_SAMPLES);
    localparam int TURN_BITS       = QTR_BITS + 2;
    localparam int TURN_STEPS      = 4 * QUARTER_SAMPLES;
    localparam int THIRD_STEPS     = TURN_STEPS / 3;

    localparam logic [TURN_BITS-1:0] THIRD_ANG       = TURN_BITS'(THIRD_STEPS);
    localparam logic [TURN_BITS-1:0] MINUS_THIRD_ANG = TURN_BITS'(TURN_STEPS - THIRD_STEPS);

    localparam logic [15:0] FULL_SQ       = 16'd65025;  // 255 * 255
    localparam logic [15:0] PWM_TOP_RESET = 16'd1999;
    localparam logic [7:0]  FULL_POWER    = 8'd255;
    // floor(2^32 / 255), used for division of the power span by 255
    localparam logic [24:0] RECIP_255     = 25'h1010101;

    // Compare-value quotient: 16 bits, resolved a few bits per pipeline stage
    localparam int QUOT_BITS      = 16;
    localparam int DIV_STAGES     = 4;
    localparam int BITS_PER_STAGE = QUOT_BITS / DIV_STAGES;

    typedef struct packed {
        logic                 ready;   // factor valid, input may be taken
        logic [QUOT_BITS-1:0] factor;  // 65025 / (top + 1) + 1
    } fac_status_t;

endpackage

// ===== hdl/scp_sine_lookup.sv =====
// Offset-sine lookup: quarter-wave ROM with registered read, mirrored and negated.
// Depends on scp_pkg; the ROM contents are built at elaboration.
`timescale 1ns / 1ps

module scp_sine_lookup (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [scp_pkg::TURN_BITS-1:0]  angle,
    output logic [7:0]                     sine
);
    import scp_pkg::*;

    localparam logic [63:0] PI_Q32 = 64'd13493037705;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Taylor series denominators (2k)(2k+1) for k = 1..12, entry 0 is k = 1
    localparam logic [11:0][9:0] TAYLOR_DEN = {
        10'd600, 10'd506, 10'd420, 10'd342, 10'd272, 10'd210,
        10'd156, 10'd110, 10'd72,  10'd42,  10'd20,  10'd6};

    typedef logic [QUARTER_SAMPLES-1:0][7:0] quarter_tab_t;

    // round(127.5 * sin(i*pi/(2Q)) + 127.5), Taylor series in Q30
    function automatic logic [7:0] quarter_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] n;
        x    = (64'(i) * PI_Q32 + 64'(4 * QUARTER_SAMPLES)) / 64'(8 * QUARTER_SAMPLES);
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = '0;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x2) >> 30) / 64'(TAYLOR_DEN[4'(k - 1)]);
            if ((k % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        s = (pos > neg) ? (pos - neg) : 64'd0;
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        n = (64'd255 * ONE_Q30 + 64'd255 * s + ONE_Q30) >> 31;
        if (n > 64'd255) begin
            n = 64'd255;
        end
        return n[7:0];
    endfunction

    function automatic quarter_tab_t build_quarter_tab();
        quarter_tab_t t;
        for (int i = 0; i < QUARTER_SAMPLES; i++) begin
            t[i] = quarter_entry(i);
        end
        return t;
    endfunction

    localparam quarter_tab_t QUARTER_TAB = build_quarter_tab();

    logic [QTR_BITS-1:0] idx;
    logic [7:0]          tab_reg;
    logic                neg_reg;

    // second and fourth quarters read the table backwards
    assign idx = angle[TURN_BITS-2] ? ~angle[QTR_BITS-1:0] : angle[QTR_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            tab_reg <= QUARTER_TAB[idx];
            neg_reg <= angle[TURN_BITS-1];
        end
    end

    // second half-wave: negate modulo 256
    assign sine = neg_reg ? 8'(~tab_reg + 8'd1) : tab_reg;

endmodule

// ===== hdl/scp_div_slice.sv =====
// One pipeline slice of the restoring divider: resolves BITS_PER_STAGE quotient bits.
// Depends on scp_pkg.
`timescale 1ns / 1ps

module scp_div_slice (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [scp_pkg::QUOT_BITS-1:0]  divisor,
    input  logic [scp_pkg::QUOT_BITS-1:0]  rem_in,
    input  logic [scp_pkg::QUOT_BITS-1:0]  num_in,
    input  logic [scp_pkg::QUOT_BITS-1:0]  quo_in,
    output logic [scp_pkg::QUOT_BITS-1:0]  rem_reg,
    output logic [scp_pkg::QUOT_BITS-1:0]  num_reg,
    output logic [scp_pkg::QUOT_BITS-1:0]  quo_reg
);
    import scp_pkg::*;

    logic [QUOT_BITS-1:0] rem_next;
    logic [QUOT_BITS-1:0] num_next;
    logic [QUOT_BITS-1:0] quo_next;

    // remainder stays below the divisor, so it never needs the 17th bit
    always_comb begin
        logic [QUOT_BITS:0] t;
        rem_next = rem_in;
        num_next = num_in;
        quo_next = quo_in;
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
            t        = {rem_next, num_next[QUOT_BITS-1]};
            num_next = {num_next[QUOT_BITS-2:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
                rem_next = QUOT_BITS'(t - {1'b0, divisor});
                quo_next = {quo_next[QUOT_BITS-2:0], 1'b1};
            end else begin
                rem_next = t[QUOT_BITS-1:0];
                quo_next = {quo_next[QUOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            quo_reg <= quo_next;
        end
    end

endmodule

// ===== hdl/scp_factor_div.sv =====
// Bit-serial divider for the duty scale factor 65025 / (top + 1) + 1.
// Depends on scp_pkg; restarts on reset and on every top write.
`timescale 1ns / 1ps

module scp_factor_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [16:0]           period,
    output scp_pkg::fac_status_t  fac
);
    import scp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam int   CNT_BITS = $clog2(QUOT_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(QUOT_BITS - 1);

    logic                 state_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [QUOT_BITS-1:0] rem_reg;
    logic [QUOT_BITS-1:0] num_reg;
    logic [QUOT_BITS-1:0] quo_reg;
    logic [QUOT_BITS-1:0] factor_reg;

    logic [QUOT_BITS:0]   t;
    logic                 ge;
    logic [QUOT_BITS-1:0] rem_next;
    logic [QUOT_BITS-1:0] quo_next;

    // remainder < period <= 65536, so 16 bits hold it
    assign t        = {rem_reg, num_reg[QUOT_BITS-1]};
    assign ge       = (t >= period);
    assign rem_next = ge ? QUOT_BITS'(t - period) : t[QUOT_BITS-1:0];
    assign quo_next = {quo_reg[QUOT_BITS-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            state_reg <= ST_RUN;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            num_reg   <= FULL_SQ;
            quo_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_RUN: begin
                    rem_reg <= rem_next;
                    num_reg <= {num_reg[QUOT_BITS-2:0], 1'b0};
                    quo_reg <= quo_next;
                    cnt_reg <= CNT_BITS'(cnt_reg + 1'b1);
                    if (cnt_reg == CNT_LAST) begin
                        state_reg  <= ST_IDLE;
                        factor_reg <= QUOT_BITS'(quo_next + 1'b1);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign fac.ready  = (state_reg == ST_IDLE);
    assign fac.factor = factor_reg;

endmodule

// ===== hdl/sine_commutation_pwm.sv =====
// Top level of the three-phase sine commutation PWM compare generator.
// Depends on scp_pkg, scp_sine_lookup, scp_div_slice and scp_factor_div.
//
// Usage:
//  - Input channel s_valid/s_ready carries one request: s_angle (4096 steps per
//    electrical turn, taken modulo the turn) and s_power (0..255).
//  - Output channel m_valid/m_ready returns start/end compare values for phases
//    U, V (+1/3 turn) and W (-1/3 turn).
//  - cfg_wr_en/cfg_wr_data write pwm_top (reset 1999); period is top + 1.
//  - Eight register stages: input, sine ROM read, power multiply, four divider
//    slices of four quotient bits each, output. One request per clock is
//    sustained while m_ready stays high and the scale factor is ready.
//  - The scale factor 65025/(top+1)+1 comes from a one-bit-per-clock divider:
//    after reset and after each pwm_top write s_ready stays low until it is done.
//  - Each stage holds a valid bit and only stalls when it and all stages after
//    it are full, so bubbles close up while m_ready is low; s_ready drops when
//    every stage holds a request or while the scale factor is recomputed.
//  - aresetn is synchronous, active low, and empties the pipeline.
`timescale 1ns / 1ps

module sine_commutation_pwm (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_angle,
    input  logic [7:0]  s_power,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_phase_u_start,
    output logic [16:0] m_phase_u_end,
    output logic [15:0] m_phase_v_start,
    output logic [16:0] m_phase_v_end,
    output logic [15:0] m_phase_w_start,
    output logic [16:0] m_phase_w_end
);
    import scp_pkg::*;

    localparam int NUM_STAGES = 3 + DIV_STAGES + 1;
    localparam int DIV_FIRST  = 3;
    localparam int OUT_STAGE  = NUM_STAGES - 1;
    localparam int NUM_PHASES = 3;

    fac_status_t fac;

    logic [15:0] pwm_top_reg;
    logic [16:0] period;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] stg_en;

    // stage 0: phase angles, power and period * power
    logic [TURN_BITS-1:0] ang_reg [NUM_PHASES];
    logic [7:0]           pow0_reg;
    logic [23:0]          prod0_reg;
    logic [TURN_BITS-1:0] ang_in;

    // stage 1: sine values, estimate of (period * power) / 255
    logic [7:0]  sine [NUM_PHASES];
    logic [7:0]  pow1_reg;
    logic [23:0] prod1_reg;
    logic [16:0] qest_reg;
    logic [48:0] recip_prod;

    // stage 2: power * sine, power span
    logic [QUOT_BITS-1:0] num2_reg [NUM_PHASES];
    logic [16:0]          span2_reg;
    logic [24:0]          qest_x255;
    logic [24:0]          rem255;
    logic [16:0]          quot255;

    // divider slices
    logic [QUOT_BITS-1:0] rem_pipe [NUM_PHASES][DIV_STAGES+1];
    logic [QUOT_BITS-1:0] num_pipe [NUM_PHASES][DIV_STAGES+1];
    logic [QUOT_BITS-1:0] quo_pipe [NUM_PHASES][DIV_STAGES+1];
    logic [16:0]          span_reg [DIV_STAGES];

    // output stage
    logic [QUOT_BITS-1:0] start_reg [NUM_PHASES];
    logic [16:0]          end_reg   [NUM_PHASES];

    //------------------------------------------------------------------
    // configuration and scale factor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_top_reg <= PWM_TOP_RESET;
        end else if (cfg_wr_en) begin
            pwm_top_reg <= cfg_wr_data;
        end
    end

    assign period = {1'b0, pwm_top_reg} + 17'd1;

    scp_factor_div u_factor_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_wr_en),
        .period  (period),
        .fac     (fac)
    );

    //------------------------------------------------------------------
    // pipeline flow control
    always_comb begin
        stg_en[OUT_STAGE] = ~vld_reg[OUT_STAGE] | m_ready;
        for (int i = OUT_STAGE - 1; i >= 0; i--) begin
            stg_en[i] = ~vld_reg[i] | stg_en[i+1];
        end
    end

    assign s_ready = stg_en[0] & fac.ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stg_en[0]) begin
                vld_reg[0] <= s_valid & fac.ready;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stg_en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    //------------------------------------------------------------------
    // stage 0
    assign ang_in = s_angle[TURN_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (stg_en[0]) begin
            ang_reg[0] <= ang_in;
            ang_reg[1] <= TURN_BITS'(ang_in + THIRD_ANG);
            ang_reg[2] <= TURN_BITS'(ang_in + MINUS_THIRD_ANG);
            pow0_reg   <= s_power;
            prod0_reg  <= 24'({7'd0, period} * {16'd0, s_power});
        end
    end

    //------------------------------------------------------------------
    // stage 1
    generate
        for (genvar p = 0; p < NUM_PHASES; p++) begin : g_sine
            scp_sine_lookup u_sine (
                .aclk  (aclk),
                .en    (stg_en[1]),
                .angle (ang_reg[p]),
                .sine  (sine[p])
            );
        end
    endgenerate

    // estimate is the true quotient or one below it
    assign recip_prod = {25'd0, prod0_reg} * {24'd0, RECIP_255};

    always_ff @(posedge aclk) begin
        if (stg_en[1]) begin
            pow1_reg  <= pow0_reg;
            prod1_reg <= prod0_reg;
            qest_reg  <= recip_prod[48:32];
        end
    end

    //------------------------------------------------------------------
    // stage 2
    assign qest_x255 = {qest_reg, 8'd0} - {8'd0, qest_reg};
    assign rem255    = {1'b0, prod1_reg} - qest_x255;
    assign quot255   = (rem255[8:0] >= 9'(FULL_POWER)) ? 17'(qest_reg + 17'd1) : qest_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[2]) begin
            for (int p = 0; p < NUM_PHASES; p++) begin
                num2_reg[p] <= QUOT_BITS'({8'd0, pow1_reg} * {8'd0, sine[p]});
            end
            span2_reg <= 17'(period - quot255);
        end
    end

    //------------------------------------------------------------------
    // divider slices: (power * sine) / factor
    generate
        for (genvar p = 0; p < NUM_PHASES; p++) begin : g_phase
            assign quo_pipe[p][0] = '0;
            assign rem_pipe[p][0] = '0;
            assign num_pipe[p][0] = num2_reg[p];
            for (genvar d = 0; d < DIV_STAGES; d++) begin : g_slice
                scp_div_slice u_div (
                    .aclk    (aclk),
                    .en      (stg_en[DIV_FIRST+d]),
                    .divisor (fac.factor),
                    .rem_in  (rem_pipe[p][d]),
                    .num_in  (num_pipe[p][d]),
                    .quo_in  (quo_pipe[p][d]),
                    .rem_reg (rem_pipe[p][d+1]),
                    .num_reg (num_pipe[p][d+1]),
                    .quo_reg (quo_pipe[p][d+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (stg_en[DIV_FIRST]) begin
            span_reg[0] <= span2_reg;
        end
        for (int d = 1; d < DIV_STAGES; d++) begin
            if (stg_en[DIV_FIRST+d]) begin
                span_reg[d] <= span_reg[d-1];
            end
        end
    end

    //------------------------------------------------------------------
    // output stage
    always_ff @(posedge aclk) begin
        if (stg_en[OUT_STAGE]) begin
            for (int p = 0; p < NUM_PHASES; p++) begin
                start_reg[p] <= quo_pipe[p][DIV_STAGES];
                end_reg[p]   <= 17'({1'b0, quo_pipe[p][DIV_STAGES]} + span_reg[DIV_STAGES-1]);
            end
        end
    end

    assign m_valid         = vld_reg[OUT_STAGE];
    assign m_phase_u_start = start_reg[0];
    assign m_phase_u_end   = end_reg[0];
    assign m_phase_v_start = start_reg[1];
    assign m_phase_v_end   = end_reg[1];
    assign m_phase_w_start = start_reg[2];
    assign m_phase_w_end   = end_reg[2];

`ifndef NO_ASSERTIONS
    a_factor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        fac.ready |-> (fac.factor != '0))
        else $error("scale factor is zero while input is open");

    a_end_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_phase_u_end >= {1'b0, m_phase_u_start}) &&
                     (m_phase_v_end >= {1'b0, m_phase_v_start}) &&
                     (m_phase_w_end >= {1'b0, m_phase_w_start})))
        else $error("end compare below start compare");

    a_out_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[OUT_STAGE-1] && stg_en[OUT_STAGE]) |=> m_valid)
        else $error("request lost entering output stage");
`endif

endmodule
